// File: src/assert_macros.svh
// assertion helpers, included by the top-level unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define VDFE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define VDFE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/vdfe_pkg.sv
// ----------------------------------------------------------------------------
// vdfe_pkg
// shared types, constants and helpers of the voxel displacement field engine
// ----------------------------------------------------------------------------
package vdfe_pkg;

    localparam int GRID_X = 32;
    localparam int GRID_Y = 32;
    localparam int GRID_Z = 32;
    localparam int VOXELS = GRID_X * GRID_Y * GRID_Z;
    localparam int IDX_W  = $clog2(VOXELS);
    // signed linear index of a corner, coordinates run from -1 to 33
    localparam int LIN_W  = $clog2(34 * GRID_X * GRID_Y + 34 * GRID_X + 35) + 1;
    localparam int LOC_W  = 13;
    localparam int VAL_W  = 32;
    localparam int PRB_W  = 15;
    localparam int CRD_W  = PRB_W - 7;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [1:0] REG_DELTA = 2'd0;
    localparam logic [1:0] REG_INV   = 2'd1;
    localparam logic [1:0] REG_GAMMA = 2'd2;

    typedef enum logic [1:0] {
        OP_ACC    = 2'd0,
        OP_FILL   = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_ENERGY = 2'd3
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [LOC_W-1:0]        loc_x;
        logic [LOC_W-1:0]        loc_y;
        logic [LOC_W-1:0]        loc_z;
        logic signed [VAL_W-1:0] val_x;
        logic signed [VAL_W-1:0] val_y;
        logic signed [VAL_W-1:0] val_z;
        logic [IDX_W-1:0]        acc_idx;
        logic                    acc_oob;
    } t_cmd;

    typedef struct packed {
        logic clearing;
        logic busy;
    } t_be_st;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_CRN_ADDR,
        ST_CRN_WGT,
        ST_CRN_PROD,
        ST_CRN_ACC,
        ST_SMP_FIN,
        ST_JAC_MUL,
        ST_JAC_SAT,
        ST_SUM_MUL,
        ST_SUM_ACC,
        ST_GAM_MUL,
        ST_GAM_FIN
    } t_bstate;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: src/vdfe_front.sv
// ----------------------------------------------------------------------------
// vdfe_front
// takes input items, decodes the function and resolves the accumulate index
// ----------------------------------------------------------------------------
module vdfe_front (
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_func,
    input  logic [vdfe_pkg::LOC_W-1:0]     i_loc_x,
    input  logic [vdfe_pkg::LOC_W-1:0]     i_loc_y,
    input  logic [vdfe_pkg::LOC_W-1:0]     i_loc_z,
    input  logic signed [vdfe_pkg::VAL_W-1:0] i_val_x,
    input  logic signed [vdfe_pkg::VAL_W-1:0] i_val_y,
    input  logic signed [vdfe_pkg::VAL_W-1:0] i_val_z,
    input  logic                           i_q_full,
    output logic                           o_push,
    output vdfe_pkg::t_cmd                 o_cmd
);
    logic [vdfe_pkg::LIN_W-1:0] w_lin;

    // voxel under the integer part of the location
    assign w_lin = vdfe_pkg::LIN_W'(i_loc_z[12:8])
                       * vdfe_pkg::LIN_W'(vdfe_pkg::GRID_X * vdfe_pkg::GRID_Y)
                 + vdfe_pkg::LIN_W'(i_loc_y[12:8]) * vdfe_pkg::LIN_W'(vdfe_pkg::GRID_X)
                 + vdfe_pkg::LIN_W'(i_loc_x[12:8]);

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = vdfe_pkg::t_op'(i_func);
        o_cmd.loc_x   = i_loc_x;
        o_cmd.loc_y   = i_loc_y;
        o_cmd.loc_z   = i_loc_z;
        o_cmd.val_x   = i_val_x;
        o_cmd.val_y   = i_val_y;
        o_cmd.val_z   = i_val_z;
        o_cmd.acc_idx = w_lin[vdfe_pkg::IDX_W-1:0];
        o_cmd.acc_oob = (w_lin >= vdfe_pkg::LIN_W'(vdfe_pkg::VOXELS));
    end
endmodule

// File: src/vdfe_queue.sv
// ----------------------------------------------------------------------------
// vdfe_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
module vdfe_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  vdfe_pkg::t_cmd                i_cmd,
    input  logic                          i_pop,
    output logic                          o_full,
    output logic                          o_empty,
    output logic [vdfe_pkg::QCNT_W-1:0]   o_count,
    output vdfe_pkg::t_cmd                o_cmd
);
    vdfe_pkg::t_cmd                      r_slot [vdfe_pkg::QDEPTH];
    logic [vdfe_pkg::QPTR_W-1:0]         r_wp, n_wp;
    logic [vdfe_pkg::QPTR_W-1:0]         r_rp, n_rp;
    logic [vdfe_pkg::QCNT_W-1:0]         r_cnt, n_cnt;

    assign o_full  = (r_cnt == vdfe_pkg::QCNT_W'(vdfe_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_cmd   = r_slot[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end
endmodule

// File: src/vdfe_back.sv
// ----------------------------------------------------------------------------
// vdfe_back
// owns the vector store and runs accumulate, fill, sample and energy
// ----------------------------------------------------------------------------
module vdfe_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    input  vdfe_pkg::t_cmd         i_cmd,
    output logic                   o_pop,
    input  logic [7:0]             i_delta_step,
    input  logic [15:0]            i_inv_two_delta,
    input  logic signed [17:0]     i_gamma_killing,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [31:0]     o_disp_x,
    output logic signed [31:0]     o_disp_y,
    output logic signed [31:0]     o_disp_z,
    output logic signed [31:0]     o_energy,
    output logic                   o_status,
    output vdfe_pkg::t_be_st       o_st
);
    localparam int AW = vdfe_pkg::IDX_W;
    localparam int LW = vdfe_pkg::LIN_W;
    localparam int PW = vdfe_pkg::PRB_W;
    localparam int CW = vdfe_pkg::CRD_W;

    vdfe_pkg::t_bstate         r_state, n_state;
    vdfe_pkg::t_cmd            r_cmd;
    logic [95:0]               mem [vdfe_pkg::VOXELS];
    logic [95:0]               r_rd;
    logic                      w_rd_en;
    logic                      w_we;
    logic [AW-1:0]             w_addr;
    logic [95:0]               w_wdata;
    logic [AW-1:0]             r_cnt;
    logic [2:0]                r_crn;
    logic [1:0]                r_axis;
    logic                      r_minus;
    logic [3:0]                r_step;
    logic                      r_ok;
    logic [17:0]               r_wxy;
    logic [8:0]                r_wz;
    logic [24:0]               r_w;
    logic signed [57:0]        r_prod [3];
    logic signed [57:0]        r_acc [3];
    logic signed [31:0]        r_plus [3];
    logic signed [32:0]        r_diff [3];
    logic signed [49:0]        r_jp [3];
    logic signed [31:0]        r_ja [9];
    logic signed [31:0]        r_jb [9];
    logic signed [63:0]        r_p1, r_p2;
    logic signed [51:0]        r_s1, r_s2;
    logic signed [53:0]        r_gh;
    logic signed [34:0]        r_gl;
    logic                      r_ov;
    logic signed [31:0]        r_ox, r_oy, r_oz, r_oe;
    logic                      r_os;
    logic                      w_start;
    logic                      w_out_free;
    logic signed [PW-1:0]      w_p [3];
    logic signed [CW-1:0]      w_c [3];
    logic [8:0]                w_wt [3];
    logic signed [LW-1:0]      w_lin;
    logic                      w_inr;
    logic signed [31:0]        w_res [3];
    logic signed [31:0]        w_jac [3];
    logic signed [31:0]        w_rdv [3];
    logic signed [55:0]        w_e;
    logic signed [PW-1:0]      w_d;

    assign w_out_free = !r_ov || i_out_ready;
    assign w_start    = (r_state == vdfe_pkg::ST_IDLE) && !i_q_empty && w_out_free;
    assign o_pop      = w_start;
    assign o_st.clearing = (r_state == vdfe_pkg::ST_CLEAR);
    assign o_st.busy     = (r_state != vdfe_pkg::ST_IDLE);

    assign o_out_valid = r_ov;
    assign o_disp_x    = r_ox;
    assign o_disp_y    = r_oy;
    assign o_disp_z    = r_oz;
    assign o_energy    = r_oe;
    assign o_status    = r_os;

    // probe point, corner coordinates, weights and linear index
    assign w_d = PW'($signed({1'b0, i_delta_step}));
    always_comb begin
        w_p[0] = PW'($signed({1'b0, r_cmd.loc_x}));
        w_p[1] = PW'($signed({1'b0, r_cmd.loc_y}));
        w_p[2] = PW'($signed({1'b0, r_cmd.loc_z}));
        for (int k = 0; k < 3; k++) begin
            if (r_cmd.op == vdfe_pkg::OP_ENERGY && r_axis == 2'(k)) begin
                w_p[k] = r_minus ? w_p[k] - w_d : w_p[k] + w_d;
            end
            // floor of the probe, negative probes included
            w_c[k]  = CW'($signed(w_p[k][PW-1:8])) + CW'(r_crn[k]);
            w_wt[k] = r_crn[k] ? {1'b0, w_p[k][7:0]} : 9'd256 - {1'b0, w_p[k][7:0]};
            w_rdv[k] = r_rd[32*k +: 32];
            w_res[k] = vdfe_pkg::sat32(64'((r_acc[k] + 58'sd8388608) >>> 24));
            w_jac[k] = vdfe_pkg::sat32(64'((r_jp[k] + 50'sd128) >>> 8));
        end
        w_lin = LW'(w_c[2]) * LW'(vdfe_pkg::GRID_X * vdfe_pkg::GRID_Y)
              + LW'(w_c[1]) * LW'(vdfe_pkg::GRID_X) + LW'(w_c[0]);
        w_inr = !w_lin[LW-1] && (w_lin < LW'(vdfe_pkg::VOXELS));
        w_e   = 56'(r_s1) + 56'(r_gh) + 56'((r_gl + 35'sd32768) >>> 16);
    end

    // store port
    always_comb begin
        w_rd_en = 1'b0;
        w_we    = 1'b0;
        w_addr  = w_lin[AW-1:0];
        w_wdata = '0;
        case (r_state)
            vdfe_pkg::ST_CLEAR: begin
                w_we   = 1'b1;
                w_addr = r_cnt;
            end
            vdfe_pkg::ST_FILL: begin
                w_we    = 1'b1;
                w_addr  = r_cnt;
                w_wdata = {r_cmd.val_z, r_cmd.val_y, r_cmd.val_x};
            end
            vdfe_pkg::ST_ACC_RD: begin
                w_rd_en = !r_cmd.acc_oob;
                w_addr  = r_cmd.acc_idx;
            end
            vdfe_pkg::ST_ACC_WR: begin
                w_we    = 1'b1;
                w_addr  = r_cmd.acc_idx;
                w_wdata = {vdfe_pkg::sat32(64'(w_rdv[2]) + 64'(r_cmd.val_z)),
                           vdfe_pkg::sat32(64'(w_rdv[1]) + 64'(r_cmd.val_y)),
                           vdfe_pkg::sat32(64'(w_rdv[0]) + 64'(r_cmd.val_x))};
            end
            vdfe_pkg::ST_CRN_ADDR: begin
                w_rd_en = w_inr;
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_addr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rd <= mem[w_addr];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            vdfe_pkg::ST_CLEAR: begin
                if (r_cnt == AW'(vdfe_pkg::VOXELS - 1)) begin
                    n_state = vdfe_pkg::ST_IDLE;
                end
            end
            vdfe_pkg::ST_IDLE: begin
                if (w_start) begin
                    case (i_cmd.op)
                        vdfe_pkg::OP_ACC:  n_state = vdfe_pkg::ST_ACC_RD;
                        vdfe_pkg::OP_FILL: n_state = vdfe_pkg::ST_FILL;
                        default:           n_state = vdfe_pkg::ST_CRN_ADDR;
                    endcase
                end
            end
            vdfe_pkg::ST_FILL: begin
                if (r_cnt == AW'(vdfe_pkg::VOXELS - 1)) begin
                    n_state = vdfe_pkg::ST_IDLE;
                end
            end
            vdfe_pkg::ST_ACC_RD: begin
                n_state = r_cmd.acc_oob ? vdfe_pkg::ST_IDLE : vdfe_pkg::ST_ACC_WR;
            end
            vdfe_pkg::ST_ACC_WR:   n_state = vdfe_pkg::ST_IDLE;
            vdfe_pkg::ST_CRN_ADDR: n_state = vdfe_pkg::ST_CRN_WGT;
            vdfe_pkg::ST_CRN_WGT:  n_state = vdfe_pkg::ST_CRN_PROD;
            vdfe_pkg::ST_CRN_PROD: n_state = vdfe_pkg::ST_CRN_ACC;
            vdfe_pkg::ST_CRN_ACC: begin
                n_state = (r_crn == 3'd7) ? vdfe_pkg::ST_SMP_FIN : vdfe_pkg::ST_CRN_ADDR;
            end
            vdfe_pkg::ST_SMP_FIN: begin
                if (r_cmd.op != vdfe_pkg::OP_ENERGY) begin
                    n_state = vdfe_pkg::ST_IDLE;
                end else if (r_minus) begin
                    n_state = vdfe_pkg::ST_JAC_MUL;
                end else begin
                    n_state = vdfe_pkg::ST_CRN_ADDR;
                end
            end
            vdfe_pkg::ST_JAC_MUL: n_state = vdfe_pkg::ST_JAC_SAT;
            vdfe_pkg::ST_JAC_SAT: begin
                n_state = (r_axis == 2'd2) ? vdfe_pkg::ST_SUM_MUL : vdfe_pkg::ST_CRN_ADDR;
            end
            vdfe_pkg::ST_SUM_MUL: n_state = vdfe_pkg::ST_SUM_ACC;
            vdfe_pkg::ST_SUM_ACC: begin
                n_state = (r_step == 4'd8) ? vdfe_pkg::ST_GAM_MUL : vdfe_pkg::ST_SUM_MUL;
            end
            vdfe_pkg::ST_GAM_MUL: n_state = vdfe_pkg::ST_GAM_FIN;
            vdfe_pkg::ST_GAM_FIN: n_state = vdfe_pkg::ST_IDLE;
            default:              n_state = vdfe_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vdfe_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                vdfe_pkg::ST_FILL: begin
                    if (r_cnt == AW'(vdfe_pkg::VOXELS - 1)) begin
                        r_ov <= 1'b1;
                    end
                end
                vdfe_pkg::ST_ACC_RD: begin
                    if (r_cmd.acc_oob) begin
                        r_ov <= 1'b1;
                    end
                end
                vdfe_pkg::ST_ACC_WR:  r_ov <= 1'b1;
                vdfe_pkg::ST_SMP_FIN: begin
                    if (r_cmd.op != vdfe_pkg::OP_ENERGY) begin
                        r_ov <= 1'b1;
                    end
                end
                vdfe_pkg::ST_GAM_FIN: r_ov <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            vdfe_pkg::ST_IDLE: begin
                // the previous result has left by the time a new item starts
                if (w_start) begin
                    r_ox <= '0;
                    r_oy <= '0;
                    r_oz <= '0;
                    r_oe <= '0;
                    r_os <= 1'b0;
                end
            end
            vdfe_pkg::ST_ACC_RD: begin
                r_os <= r_cmd.acc_oob;
            end
            vdfe_pkg::ST_SMP_FIN: begin
                if (r_cmd.op != vdfe_pkg::OP_ENERGY) begin
                    r_ox <= w_res[0];
                    r_oy <= w_res[1];
                    r_oz <= w_res[2];
                end
            end
            vdfe_pkg::ST_GAM_FIN: begin
                r_oe <= vdfe_pkg::sat32(64'(w_e));
            end
            default: begin
            end
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case (r_state)
                vdfe_pkg::ST_CLEAR, vdfe_pkg::ST_FILL: r_cnt <= r_cnt + 1'b1;
                default:                               r_cnt <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            vdfe_pkg::ST_IDLE: begin
                if (w_start) begin
                    r_cmd <= i_cmd;
                end
                r_crn   <= '0;
                r_axis  <= '0;
                r_minus <= 1'b0;
                for (int k = 0; k < 3; k++) begin
                    r_acc[k] <= '0;
                end
            end
            vdfe_pkg::ST_CRN_ADDR: begin
                r_ok  <= w_inr;
                r_wxy <= w_wt[0] * w_wt[1];
                r_wz  <= w_wt[2];
            end
            vdfe_pkg::ST_CRN_WGT: begin
                r_w <= 25'(r_wxy) * 25'(r_wz);
            end
            vdfe_pkg::ST_CRN_PROD: begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[k] <= r_ok ? 58'(w_rdv[k]) * 58'($signed({1'b0, r_w})) : '0;
                end
            end
            vdfe_pkg::ST_CRN_ACC: begin
                for (int k = 0; k < 3; k++) begin
                    r_acc[k] <= r_acc[k] + r_prod[k];
                end
                r_crn <= r_crn + 1'b1;
            end
            vdfe_pkg::ST_SMP_FIN: begin
                for (int k = 0; k < 3; k++) begin
                    r_acc[k]  <= '0;
                    r_plus[k] <= w_res[k];
                    r_diff[k] <= 33'(r_plus[k]) - 33'(w_res[k]);
                end
                r_minus <= !r_minus;
            end
            vdfe_pkg::ST_JAC_MUL: begin
                for (int k = 0; k < 3; k++) begin
                    r_jp[k] <= 50'(r_diff[k]) * 50'($signed({1'b0, i_inv_two_delta}));
                end
            end
            vdfe_pkg::ST_JAC_SAT: begin
                // row major copy and transposed copy of the jacobian
                for (int j = 0; j < 3; j++) begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_axis == 2'(i)) begin
                            r_ja[j * 3 + i] <= w_jac[j];
                            r_jb[i * 3 + j] <= w_jac[j];
                        end
                    end
                end
                r_axis <= r_axis + 1'b1;
                r_step <= '0;
                r_s1   <= '0;
                r_s2   <= '0;
            end
            vdfe_pkg::ST_SUM_MUL: begin
                r_p1 <= r_ja[0] * r_ja[0];
                r_p2 <= r_ja[0] * r_jb[0];
            end
            vdfe_pkg::ST_SUM_ACC: begin
                r_s1 <= r_s1 + 52'((r_p1 + 64'sd32768) >>> 16);
                r_s2 <= r_s2 + 52'((r_p2 + 64'sd32768) >>> 16);
                for (int n = 0; n < 8; n++) begin
                    r_ja[n] <= r_ja[n + 1];
                    r_jb[n] <= r_jb[n + 1];
                end
                r_step <= r_step + 1'b1;
            end
            vdfe_pkg::ST_GAM_MUL: begin
                r_gh <= 54'(i_gamma_killing) * 54'($signed(r_s2[51:16]));
                r_gl <= 35'(i_gamma_killing) * 35'($signed({1'b0, r_s2[15:0]}));
            end
            default: begin
            end
        endcase
    end
endmodule

// File: src/voxel_displacement_field_engine_unit.sv
// ----------------------------------------------------------------------------
// voxel_displacement_field_engine_unit
// 3d grid of q16.16 displacement vectors with trilinear sampling and energy
// ----------------------------------------------------------------------------
// Items are taken by a front decoder into a two-entry command queue, and a
// back sequencer that owns the single-port vector store executes them one at
// a time, so new items are taken while a result waits in the output register.
// After reset the back part first sweeps the store to zero, one voxel per
// cycle, and takes no queued item until the sweep ends; the configuration
// port works throughout. Steps per item: accumulate reads the voxel and
// writes the sum back (no write when ignored), fill writes one voxel a
// cycle, sample runs eight corners through address, weight, product and
// accumulate states and then a rounding state, energy takes six samples,
// a jacobian multiply and saturate per axis, nine product steps, and a
// gamma multiply and final sum for the transpose weight.
module voxel_displacement_field_engine_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_func,
    input  logic [12:0]        i_loc_x,
    input  logic [12:0]        i_loc_y,
    input  logic [12:0]        i_loc_z,
    input  logic signed [31:0] i_val_x,
    input  logic signed [31:0] i_val_y,
    input  logic signed [31:0] i_val_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_disp_x,
    output logic signed [31:0] o_disp_y,
    output logic signed [31:0] o_disp_z,
    output logic signed [31:0] o_energy,
    output logic               o_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
`include "assert_macros.svh"

    // configuration registers
    logic [7:0]                         r_delta;
    logic [15:0]                        r_inv;
    logic signed [17:0]                 r_gamma;
    logic                               w_cfg_wr;

    // front to queue to back
    logic                               w_push;
    logic                               w_pop;
    logic                               w_q_full;
    logic                               w_q_empty;
    logic [vdfe_pkg::QCNT_W-1:0]        w_q_count;
    vdfe_pkg::t_cmd                     w_cmd_in;
    vdfe_pkg::t_cmd                     w_cmd_out;
    vdfe_pkg::t_be_st                   w_be_st;

    assign pready   = 1'b1;
    // register written in the access phase of an apb write transfer
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta <= 8'd128;
            r_inv   <= 16'd256;
            r_gamma <= 18'sd6554;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                vdfe_pkg::REG_DELTA: r_delta <= pwdata[7:0];
                vdfe_pkg::REG_INV:   r_inv   <= pwdata[15:0];
                vdfe_pkg::REG_GAMMA: r_gamma <= pwdata[17:0];
                default: begin
                end
            endcase
        end
    end

    // read back, gamma sign extended
    always_comb begin
        case (paddr[3:2])
            vdfe_pkg::REG_DELTA: prdata = {24'd0, r_delta};
            vdfe_pkg::REG_INV:   prdata = {16'd0, r_inv};
            vdfe_pkg::REG_GAMMA: prdata = 32'(r_gamma);
            default:             prdata = '0;
        endcase
    end

    // decode and accumulate index resolution
    vdfe_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_func     (i_func),
        .i_loc_x    (i_loc_x),
        .i_loc_y    (i_loc_y),
        .i_loc_z    (i_loc_z),
        .i_val_x    (i_val_x),
        .i_val_y    (i_val_y),
        .i_val_z    (i_val_z),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    // decouples input transfers from the long-running back part
    vdfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_count (w_q_count),
        .o_cmd   (w_cmd_out)
    );

    // store, sampler, jacobian and energy sequencer
    vdfe_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (w_q_empty),
        .i_cmd           (w_cmd_out),
        .o_pop           (w_pop),
        .i_delta_step    (r_delta),
        .i_inv_two_delta (r_inv),
        .i_gamma_killing (r_gamma),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_disp_x        (o_disp_x),
        .o_disp_y        (o_disp_y),
        .o_disp_z        (o_disp_z),
        .o_energy        (o_energy),
        .o_status        (o_status),
        .o_st            (w_be_st)
    );

    // no command leaves the queue during the clearing sweep
    `VDFE_ASSERT(a_no_pop_in_clear, i_clk, i_rst_n, w_be_st.clearing |-> !w_pop, "pop during clear")
    // queue never overfills
    `VDFE_ASSERT(a_queue_bound, i_clk, i_rst_n, w_q_count <= vdfe_pkg::QCNT_W'(vdfe_pkg::QDEPTH), "queue overflow")
    // an ignored accumulate carries zero energy and zero x displacement
    `VDFE_ASSERT(a_status_clean, i_clk, i_rst_n, (o_out_valid && o_status) |-> (o_energy == 32'sd0 && o_disp_x == 32'sd0), "flagged result not clean")
endmodule
